[rtl/point_line_projection_3d_assert.svh]
// Assertion macros for the point-to-line projection block.
`ifndef POINT_LINE_PROJECTION_3D_ASSERT_SVH
`define POINT_LINE_PROJECTION_3D_ASSERT_SVH
`ifndef ASSERT_OFF
`define PLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define PLP_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error("delayed check failed");
`else
`define PLP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PLP_ASSERT_DELAY(label, clk, rst, ante, n, cons)
`endif
`endif

[rtl/plp_pkg.sv]
// Types, widths and pipeline stage numbers for the point-to-line projection block.
package plp_pkg;

   localparam int DIV_STEPS = 34;
   localparam int DEN_W = 64;
   localparam int PROD_W = DEN_W + DIV_STEPS - 1;
   localparam int QR_W = DIV_STEPS + 1;
   localparam int FOOT_W = 35;
   localparam int DIFF_W = FOOT_W + 1;
   localparam int SQ_W = 2 * DIFF_W;
   localparam int SQRT_STEPS = 37;
   localparam int ROOT_W = SQRT_STEPS;
   localparam int RAD_W = 2 * SQRT_STEPS;
   localparam int SQREM_W = ROOT_W + 3;

   localparam int STG_PA = 0;
   localparam int STG_PROD = 1;
   localparam int STG_SUM = 2;
   localparam int STG_MAG = 3;
   localparam int STG_PART = 4;
   localparam int STG_DIV0 = 5;
   localparam int STG_DIVN = STG_DIV0 + DIV_STEPS;
   localparam int STG_RND = STG_DIVN + 1;
   localparam int STG_FOOT = STG_RND + 1;
   localparam int STG_DIFF = STG_FOOT + 1;
   localparam int STG_SQ = STG_DIFF + 1;
   localparam int STG_SQ0 = STG_SQ + 1;
   localparam int STG_SQN = STG_SQ0 + SQRT_STEPS;
   localparam int STG_OUT = STG_SQN + 1;
   localparam int PIPE_DEPTH = STG_OUT + 1;
   localparam int RES_LAST = STG_SQN - STG_DIFF;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
      logic signed [31:0] query_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] foot_x;
      logic signed [31:0] foot_y;
      logic signed [31:0] foot_z;
      logic [31:0]        distance;
      logic               degenerate;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic [2:0][31:0] p;
      logic [2:0][31:0] v;
      logic [2:0][31:0] a;
      logic             neg_num;
      logic             degen;
   } side_type;

   typedef struct packed {
      logic [2:0][DEN_W-1:0]     rem;
      logic [2:0][DIV_STEPS-1:0] low;
      logic [DEN_W-1:0]          den;
   } div_stage_type;

   typedef struct packed {
      logic [SQREM_W-1:0] rem;
      logic [ROOT_W-1:0]  root;
      logic [RAD_W-1:0]   rad;
   } sqrt_stage_type;

   typedef struct packed {
      logic [2:0][31:0] foot;
      logic             degen;
      logic             ovf;
   } res_type;

endpackage

[rtl/plp_div_cell.sv]
// One restoring division step for all three coordinate lanes, registered.
module plp_div_cell (
   input  logic                    clock,
   input  plp_pkg::div_stage_type  prev_stage,
   output plp_pkg::div_stage_type  stage_out
);

   plp_pkg::div_stage_type stage_ff;
   plp_pkg::div_stage_type stage_in;
   logic [plp_pkg::DEN_W:0] rem_sh [3];
   logic [plp_pkg::DEN_W:0] rem_diff [3];
   logic                    ge [3];

   always_comb begin
      stage_in = prev_stage;
      for (int i = 0; i < 3; i++) begin
         rem_sh[i] = {prev_stage.rem[i], prev_stage.low[i][plp_pkg::DIV_STEPS-1]};
         ge[i] = rem_sh[i] >= {1'b0, prev_stage.den};
         rem_diff[i] = rem_sh[i] - {1'b0, prev_stage.den};
         stage_in.rem[i] = ge[i] ? rem_diff[i][plp_pkg::DEN_W-1:0]
                                 : rem_sh[i][plp_pkg::DEN_W-1:0];
         stage_in.low[i] = {prev_stage.low[i][plp_pkg::DIV_STEPS-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_out = stage_ff;

endmodule

[rtl/plp_sqrt_cell.sv]
// One digit step of the integer square root, registered.
module plp_sqrt_cell (
   input  logic                    clock,
   input  plp_pkg::sqrt_stage_type prev_stage,
   output plp_pkg::sqrt_stage_type stage_out
);

   plp_pkg::sqrt_stage_type    stage_ff;
   plp_pkg::sqrt_stage_type    stage_in;
   logic [plp_pkg::SQREM_W-1:0] rem_sh;
   logic [plp_pkg::SQREM_W-1:0] trial;
   logic                        ge;

   always_comb begin
      rem_sh = {prev_stage.rem[plp_pkg::SQREM_W-3:0],
                prev_stage.rad[plp_pkg::RAD_W-1:plp_pkg::RAD_W-2]};
      trial = {1'b0, prev_stage.root, 2'b01};
      ge = rem_sh >= trial;
      stage_in.rem = ge ? (rem_sh - trial) : rem_sh;
      stage_in.root = {prev_stage.root[plp_pkg::ROOT_W-2:0], ge};
      stage_in.rad = {prev_stage.rad[plp_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_out = stage_ff;

endmodule

[rtl/point_line_projection_3d.sv]
// Top level of the pipelined point-to-line projection block.
// The result strobe is the valid pipeline bit of the output stage.
// Throughput: one transaction every clock cycle; busy stays low.
// The depth is set by the 34-cell divider chain and the 37-cell square root chain.
// Reset clears the valid pipeline only; transactions in flight are dropped.
`include "point_line_projection_3d_assert.svh"

module point_line_projection_3d (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  plp_pkg::req_type  req_data,
   output logic              rsp_valid,
   output plp_pkg::rsp_type  rsp_data
);

   logic                                accept;
   logic [plp_pkg::PIPE_DEPTH-1:0]      vld_ff;
   logic [plp_pkg::PIPE_DEPTH-1:0]      vld_in;
   plp_pkg::side_type                   side_ff [plp_pkg::STG_FOOT+1];
   plp_pkg::side_type                   side0_in;
   plp_pkg::side_type                   side_mag_in;
   logic signed [32:0]                  pa_in [3];
   logic signed [32:0]                  pa_ff [3];
   logic signed [63:0]                  vsq_in [3];
   logic [63:0]                         vsq_ff [3];
   logic signed [64:0]                  pv_in [3];
   logic signed [64:0]                  pv_ff [3];
   logic [plp_pkg::DEN_W-1:0]           den_ff;
   logic [plp_pkg::DEN_W-1:0]           den3_ff;
   logic [plp_pkg::DEN_W-1:0]           den4_ff;
   logic signed [66:0]                  num_ff;
   logic [64:0]                         nmag_ff;
   logic [31:0]                         vm_in [3];
   logic [63:0]                         pp_lo_ff [3];
   logic [64:0]                         pp_hi_ff [3];
   logic [plp_pkg::PROD_W-1:0]          prod_in [3];
   plp_pkg::div_stage_type              div0_in;
   plp_pkg::div_stage_type              div_head_ff;
   plp_pkg::div_stage_type              div_stage [plp_pkg::DIV_STEPS+1];
   logic                                rnd [3];
   logic [plp_pkg::QR_W-1:0]            qr_ff [3];
   logic signed [plp_pkg::FOOT_W-1:0]   pext [3];
   logic signed [plp_pkg::FOOT_W-1:0]   foot_in [3];
   logic signed [plp_pkg::FOOT_W-1:0]   foot_ff [3];
   logic signed [plp_pkg::DIFF_W-1:0]   d_in [3];
   logic signed [plp_pkg::DIFF_W-1:0]   d_ff [3];
   logic signed [plp_pkg::SQ_W-1:0]     sq_in [3];
   logic [plp_pkg::SQ_W-1:0]            sq_ff [3];
   logic                                fits [3];
   plp_pkg::res_type                    res0_in;
   plp_pkg::res_type                    res_ff [plp_pkg::RES_LAST+1];
   plp_pkg::sqrt_stage_type             sq0_in;
   plp_pkg::sqrt_stage_type             sq_head_ff;
   plp_pkg::sqrt_stage_type             sqrt_stage [plp_pkg::SQRT_STEPS+1];
   plp_pkg::rsp_type                    rsp_in;
   plp_pkg::rsp_type                    rsp_ff;
   plp_pkg::res_type                    res_last;
   plp_pkg::sqrt_stage_type             sq_last;
   logic                                dist_sat;
   logic                                div_chk_en;
   logic                                div_rem_ok;
   logic                                sqrt_rem_ok;

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[plp_pkg::PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      side0_in.p = {req_data.origin_z, req_data.origin_y, req_data.origin_x};
      side0_in.v = {req_data.dir_z, req_data.dir_y, req_data.dir_x};
      side0_in.a = {req_data.query_z, req_data.query_y, req_data.query_x};
      side0_in.neg_num = 1'b0;
      side0_in.degen = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pa_in[i] = $signed({side0_in.a[i][31], side0_in.a[i]})
                  - $signed({side0_in.p[i][31], side0_in.p[i]});
      end
      side_mag_in = side_ff[plp_pkg::STG_SUM];
      side_mag_in.neg_num = num_ff[66];
      side_mag_in.degen = (den_ff == '0);
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side0_in;
      for (int k = 1; k <= plp_pkg::STG_FOOT; k++) begin
         if (k == plp_pkg::STG_MAG) begin
            side_ff[k] <= side_mag_in;
         end else begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsq_in[i] = $signed(side_ff[plp_pkg::STG_PA].v[i])
                   * $signed(side_ff[plp_pkg::STG_PA].v[i]);
         pv_in[i] = pa_ff[i] * $signed(side_ff[plp_pkg::STG_PA].v[i]);
         vm_in[i] = side_ff[plp_pkg::STG_MAG].v[i][31] ?
                    (~side_ff[plp_pkg::STG_MAG].v[i] + 32'd1) :
                    side_ff[plp_pkg::STG_MAG].v[i];
         prod_in[i] = {pp_hi_ff[i], 32'b0} + {33'b0, pp_lo_ff[i]};
         div0_in.rem[i] = {1'b0, prod_in[i][plp_pkg::PROD_W-1:plp_pkg::DIV_STEPS]};
         div0_in.low[i] = prod_in[i][plp_pkg::DIV_STEPS-1:0];
      end
      div0_in.den = den4_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pa_ff[i] <= pa_in[i];
         vsq_ff[i] <= vsq_in[i];
         pv_ff[i] <= pv_in[i];
         pp_lo_ff[i] <= nmag_ff[31:0] * vm_in[i];
         pp_hi_ff[i] <= nmag_ff[64:32] * vm_in[i];
      end
      den_ff <= vsq_ff[0] + vsq_ff[1] + vsq_ff[2];
      num_ff <= 67'(pv_ff[0]) + 67'(pv_ff[1]) + 67'(pv_ff[2]);
      nmag_ff <= num_ff[66] ? 65'(-num_ff) : 65'(num_ff);
      den3_ff <= den_ff;
      den4_ff <= den3_ff;
      div_head_ff <= div0_in;
   end

   assign div_stage[0] = div_head_ff;

   for (genvar j = 0; j < plp_pkg::DIV_STEPS; j++) begin : g_div
      plp_div_cell u_cell (
         .clock      (clock),
         .prev_stage (div_stage[j]),
         .stage_out  (div_stage[j+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i] = {div_stage[plp_pkg::DIV_STEPS].rem[i], 1'b0}
                  >= {1'b0, div_stage[plp_pkg::DIV_STEPS].den};
         pext[i] = $signed({{3{side_ff[plp_pkg::STG_RND].p[i][31]}},
                            side_ff[plp_pkg::STG_RND].p[i]});
         if (side_ff[plp_pkg::STG_RND].degen) begin
            foot_in[i] = pext[i];
         end else if (side_ff[plp_pkg::STG_RND].neg_num
                      ^ side_ff[plp_pkg::STG_RND].v[i][31]) begin
            foot_in[i] = pext[i] - $signed(qr_ff[i]);
         end else begin
            foot_in[i] = pext[i] + $signed(qr_ff[i]);
         end
         d_in[i] = $signed({foot_ff[i][plp_pkg::FOOT_W-1], foot_ff[i]})
                 - $signed({{4{side_ff[plp_pkg::STG_FOOT].a[i][31]}},
                            side_ff[plp_pkg::STG_FOOT].a[i]});
         fits[i] = (foot_ff[i][plp_pkg::FOOT_W-1:31] == '0)
                || (foot_ff[i][plp_pkg::FOOT_W-1:31] == '1);
         res0_in.foot[i] = fits[i] ? foot_ff[i][31:0] :
                           (foot_ff[i][plp_pkg::FOOT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
         sq_in[i] = d_ff[i] * d_ff[i];
      end
      res0_in.degen = side_ff[plp_pkg::STG_FOOT].degen;
      res0_in.ovf = !fits[0] || !fits[1] || !fits[2];
      sq0_in.rem = '0;
      sq0_in.root = '0;
      sq0_in.rad = plp_pkg::RAD_W'(sq_ff[0]) + plp_pkg::RAD_W'(sq_ff[1])
                 + plp_pkg::RAD_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         qr_ff[i] <= {1'b0, div_stage[plp_pkg::DIV_STEPS].low[i]}
                   + {{(plp_pkg::QR_W-1){1'b0}}, rnd[i]};
         foot_ff[i] <= foot_in[i];
         d_ff[i] <= d_in[i];
         sq_ff[i] <= sq_in[i];
      end
      res_ff[0] <= res0_in;
      for (int k = 1; k <= plp_pkg::RES_LAST; k++) begin
         res_ff[k] <= res_ff[k-1];
      end
      sq_head_ff <= sq0_in;
   end

   assign sqrt_stage[0] = sq_head_ff;

   for (genvar j = 0; j < plp_pkg::SQRT_STEPS; j++) begin : g_sqrt
      plp_sqrt_cell u_cell (
         .clock      (clock),
         .prev_stage (sqrt_stage[j]),
         .stage_out  (sqrt_stage[j+1])
      );
   end

   always_comb begin
      res_last = res_ff[plp_pkg::RES_LAST];
      sq_last = sqrt_stage[plp_pkg::SQRT_STEPS];
      dist_sat = (sq_last.root[plp_pkg::ROOT_W-1:32] != '0);
      rsp_in.foot_x = res_last.foot[0];
      rsp_in.foot_y = res_last.foot[1];
      rsp_in.foot_z = res_last.foot[2];
      rsp_in.distance = dist_sat ? 32'hFFFF_FFFF : sq_last.root[31:0];
      rsp_in.degenerate = res_last.degen;
      rsp_in.overflow = res_last.ovf || dist_sat;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
   assign rsp_valid = vld_ff[plp_pkg::STG_OUT];

   always_comb begin
      div_chk_en = vld_ff[plp_pkg::STG_DIVN] && !side_ff[plp_pkg::STG_DIVN].degen;
      div_rem_ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (div_stage[plp_pkg::DIV_STEPS].rem[i] >= div_stage[plp_pkg::DIV_STEPS].den) begin
            div_rem_ok = 1'b0;
         end
      end
      sqrt_rem_ok = sq_last.rem <= {2'b00, sq_last.root, 1'b0};
   end

   `PLP_ASSERT_DELAY(a_latency, clock, reset, accept, plp_pkg::PIPE_DEPTH, rsp_valid)
   `PLP_ASSERT_IMPLY(a_div_rem, clock, reset, div_chk_en, div_rem_ok)
   `PLP_ASSERT_IMPLY(a_sqrt_rem, clock, reset, vld_ff[plp_pkg::STG_SQN], sqrt_rem_ok)

endmodule

[bench/plp_checker.sv]
// Checker that predicts and compares the results of the point-to-line projection block.
`timescale 1ns / 1ps

module plp_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  plp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  plp_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               seen_count,
   output int               degen_count,
   output int               ovf_count
);

   plp_pkg::rsp_type expected_q[$];

   function automatic logic [63:0] round_quot(logic [127:0] n, logic [63:0] den);
      logic [127:0] q;
      logic [127:0] r;
      q = n / {64'd0, den};
      r = n % {64'd0, den};
      if (r >= {64'd0, den} - r) q = q + 1;
      return q[63:0];
   endfunction

   function automatic logic [36:0] floor_root(logic [127:0] s);
      logic [36:0]  r;
      logic [36:0]  cand;
      logic [127:0] sq;
      r = '0;
      for (int b = 36; b >= 0; b--) begin
         cand = r | (37'd1 << b);
         sq = {91'd0, cand} * {91'd0, cand};
         if (sq <= s) r = cand;
      end
      return r;
   endfunction

   function automatic plp_pkg::rsp_type project(plp_pkg::req_type t);
      plp_pkg::rsp_type   res;
      logic signed [63:0] p[3];
      logic signed [63:0] v[3];
      logic signed [63:0] a[3];
      logic signed [63:0] foot;
      logic signed [63:0] off;
      logic signed [63:0] d;
      logic signed [127:0] num;
      logic [127:0]       nmag;
      logic [127:0]       sumsq;
      logic [63:0]        den;
      logic [63:0]        vm;
      logic [63:0]        q;
      logic [36:0]        root;
      logic               neg_num;
      p = '{t.origin_x, t.origin_y, t.origin_z};
      v = '{t.dir_x, t.dir_y, t.dir_z};
      a = '{t.query_x, t.query_y, t.query_z};
      den = '0;
      num = '0;
      sumsq = '0;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         den = den + 64'(v[i] * v[i]);
         num = num + 128'(a[i] - p[i]) * 128'(v[i]);
      end
      res.degenerate = (den == 0);
      neg_num = num[127];
      nmag = neg_num ? -num : num;
      for (int i = 0; i < 3; i++) begin
         off = 0;
         if (!res.degenerate) begin
            vm = v[i] < 0 ? -v[i] : v[i];
            q = round_quot(nmag * {64'd0, vm}, den);
            off = neg_num != (v[i] < 0) ? -q : q;
         end
         foot = p[i] + off;
         d = foot - a[i];
         sumsq = sumsq + 128'(d) * 128'(d);
         if (foot > 64'sd2147483647) begin
            foot = 64'sd2147483647;
            res.overflow = 1'b1;
         end
         if (foot < -64'sd2147483648) begin
            foot = -64'sd2147483648;
            res.overflow = 1'b1;
         end
         if (i == 0) res.foot_x = foot[31:0];
         if (i == 1) res.foot_y = foot[31:0];
         if (i == 2) res.foot_z = foot[31:0];
      end
      root = floor_root(sumsq);
      if (root > 37'hFFFFFFFF) begin
         res.distance = '1;
         res.overflow = 1'b1;
      end else begin
         res.distance = root[31:0];
      end
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
      seen_count = 0;
      degen_count = 0;
      ovf_count = 0;
   end

   always @(posedge clock) begin
      plp_pkg::rsp_type want;
      if (!reset && start && !busy) expected_q.push_back(project(req_data));
      if (!reset && rsp_valid) begin
         seen_count <= seen_count + 1;
         if (expected_q.size() == 0) begin
            $error("result with no transaction outstanding");
            fail_count <= fail_count + 1;
         end else begin
            want = expected_q.pop_front();
            if (want.degenerate) degen_count <= degen_count + 1;
            if (want.overflow) ovf_count <= ovf_count + 1;
            if (rsp_data !== want) fail_count <= fail_count + 1;
            if (rsp_data.foot_x !== want.foot_x)
               $error("foot_x expected %h actual %h", want.foot_x, rsp_data.foot_x);
            if (rsp_data.foot_y !== want.foot_y)
               $error("foot_y expected %h actual %h", want.foot_y, rsp_data.foot_y);
            if (rsp_data.foot_z !== want.foot_z)
               $error("foot_z expected %h actual %h", want.foot_z, rsp_data.foot_z);
            if (rsp_data.distance !== want.distance)
               $error("distance expected %h actual %h", want.distance, rsp_data.distance);
            if (rsp_data.degenerate !== want.degenerate)
               $error("degenerate expected %b actual %b", want.degenerate,
                      rsp_data.degenerate);
            if (rsp_data.overflow !== want.overflow)
               $error("overflow expected %b actual %b", want.overflow, rsp_data.overflow);
         end
      end
      pending <= expected_q.size();
   end

endmodule

[bench/tb_point_line_projection_3d.sv]
// Testbench top for the point-to-line projection block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_point_line_projection_3d;

   localparam int LATENCY = 83;
   localparam int IDLE_LIMIT = 2000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   plp_pkg::req_type req_data;
   logic             rsp_valid;
   plp_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending;
   int               seen_count;
   int               degen_count;
   int               ovf_count;
   int               idle_cycles;
   int               sent;

   point_line_projection_3d DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   plp_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending), .seen_count(seen_count), .degen_count(degen_count),
      .ovf_count(ovf_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] pick_value(int mode);
      logic [31:0] x;
      case (mode)
         0: x = $urandom();
         1: x = $urandom_range(0, 3) << 16;
         2: x = 32'($signed($urandom_range(0, 400)) - 200) <<< 12;
         3: x = {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom())};
         4: x = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: x = 32'($signed($urandom_range(0, 20)) - 10);
      endcase
      return x;
   endfunction

   function automatic plp_pkg::req_type random_query();
      plp_pkg::req_type t;
      int               mode;
      mode = $urandom_range(0, 5);
      t.origin_x = pick_value(mode);
      t.origin_y = pick_value(mode);
      t.origin_z = pick_value(mode);
      t.query_x = pick_value($urandom_range(0, 5));
      t.query_y = pick_value(mode);
      t.query_z = pick_value(mode);
      if ($urandom_range(0, 15) == 0) begin
         t.dir_x = 0;
         t.dir_y = 0;
         t.dir_z = 0;
      end else begin
         t.dir_x = pick_value($urandom_range(0, 5));
         t.dir_y = $urandom_range(0, 3) == 0 ? 32'd0 : pick_value(mode);
         t.dir_z = pick_value(mode);
      end
      return t;
   endfunction

   task automatic issue(plp_pkg::req_type t);
      int gap;
      gap = $urandom_range(0, 9) < 6 ? 0 :
            ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 4));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   initial begin
      plp_pkg::req_type t;
      logic [31:0]      ext[4];
      ext = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF};
      sent = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 4; i++) begin
         t = {9{ext[i]}};
         issue(t);
      end
      t = '0;
      t.query_x = 32'h00030000;
      issue(t);
      t = '0;
      t.origin_x = 32'h80000000;
      t.query_x = 32'h7FFFFFFF;
      t.query_y = 32'h7FFFFFFF;
      t.query_z = 32'h80000000;
      issue(t);
      t = '0;
      t.dir_x = 32'h00010000;
      t.query_x = 32'h00020000;
      t.query_y = 32'h00050000;
      issue(t);
      t = '0;
      t.origin_x = 32'h7FFFFFFF;
      t.dir_x = 32'h00000001;
      t.dir_y = 32'h00000001;
      t.query_x = 32'h80000000;
      t.query_y = 32'h7FFFFFFF;
      issue(t);
      t = '0;
      t.dir_x = 32'h00000003;
      t.query_x = 32'h00000001;
      t.query_y = 32'h00000001;
      issue(t);
      t = '0;
      t.dir_x = 32'h00000002;
      t.query_x = 32'h00000001;
      issue(t);
      t = '0;
      t.dir_x = 32'h80000000;
      t.dir_y = 32'h80000000;
      t.dir_z = 32'h80000000;
      t.query_x = 32'h7FFFFFFF;
      t.query_y = 32'h80000000;
      t.query_z = 32'h12345678;
      issue(t);
      t = '0;
      t.origin_x = 32'h7FFFFFFF;
      t.origin_y = 32'h80000000;
      t.dir_x = 32'h00000001;
      t.dir_y = 32'h7FFFFFFF;
      t.query_x = 32'h80000000;
      t.query_y = 32'h7FFFFFFF;
      t.query_z = 32'h80000000;
      issue(t);
      for (int i = 0; i < 600; i++) issue(random_query());
      start <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      idle_cycles = 0;
      wait (sent == 612);
      @(posedge clock);
      wait (pending == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d transactions, checked %0d results.", sent, seen_count);
      $display("Degenerate lines: %0d, saturated results: %0d.", degen_count, ovf_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/plp_pkg.sv
rtl/plp_div_cell.sv
rtl/plp_sqrt_cell.sv
rtl/point_line_projection_3d.sv
bench/plp_checker.sv
bench/tb_point_line_projection_3d.sv
